[hdl/planar_pose_integrator_core_defines.svh]
// Assertion macros for the pose integrator controller.
// No dependencies.
`ifndef PLANAR_POSE_INTEGRATOR_CORE_DEFINES_SVH
`define PLANAR_POSE_INTEGRATOR_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define PPI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define PPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hdl/ppi_pkg.sv]
// Shared types, constants and command structs for the pose integrator.
// No dependencies.
`default_nettype none
package ppi_pkg;
    localparam int POS_WIDTH_DEF     = 32;
    localparam int POS_FRAC_BITS_DEF = 16;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int COUNT_WIDTH_DEF   = 16;
    localparam int ROT_STEPS         = 28;
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
    localparam logic [31:0] GAIN_Q31   = 32'd1304065748;
    localparam logic [15:0] STEP_LIMIT_RESET = 16'd10000;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    localparam logic [2:0] MODE_STOP   = 3'd0;
    localparam logic [2:0] MODE_PAUSE  = 3'd1;
    localparam logic [2:0] MODE_CRAWL  = 3'd2;
    localparam logic [2:0] MODE_CREEP  = 3'd3;
    localparam logic [2:0] MODE_TARGET = 3'd4;

    localparam logic [2:0] REG_CENTRE_X   = 3'd0;
    localparam logic [2:0] REG_CENTRE_Y   = 3'd1;
    localparam logic [2:0] REG_TURN_STEP  = 3'd2;
    localparam logic [2:0] REG_CREEP_X    = 3'd3;
    localparam logic [2:0] REG_CREEP_Y    = 3'd4;
    localparam logic [2:0] REG_MOVE_DX    = 3'd5;
    localparam logic [2:0] REG_MOVE_DY    = 3'd6;
    localparam logic [2:0] REG_STEP_LIMIT = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BODY, ST_MUL, ST_DIV, ST_SAT, ST_GAIN, ST_ROT, ST_SUM, ST_OUT
    } ctrl_state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;   // latch the input item
        logic body;      // form crawl products / start divide
        logic mul;       // upper half of the crawl scale product
        logic div_step;  // one restoring divide step
        logic sat;       // saturate body step
        logic gain;      // gain prescale and quadrant rotation
        logic rot_step;  // one CORDIC micro-rotation
        logic commit;    // write back pose, mode and count
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_tick_moving;
        logic is_target;
        logic div_done;
        logic rot_done;
    } dp_stat_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
            default: r = 32'h0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

[hdl/ppi_ctrl.sv]
// Sequencing state machine for the pose integrator.
// Depends on ppi_pkg and the assertion macro header.
`default_nettype none
`include "planar_pose_integrator_core_defines.svh"
module ppi_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_fire,
    input  wire logic            out_busy,
    input  wire logic            out_fire,
    input  wire ppi_pkg::dp_stat_t stat,
    output ppi_pkg::dp_cmd_t     cmd,
    output logic                 ready,
    output logic                 load_out
);
    ppi_pkg::ctrl_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ppi_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppi_pkg::ST_IDLE:
                if (in_fire) state_next = ppi_pkg::ST_BODY;
            ppi_pkg::ST_BODY:
            begin
                if (!stat.is_tick_moving)    state_next = ppi_pkg::ST_SUM;
                else if (stat.is_target)     state_next = ppi_pkg::ST_DIV;
                else                         state_next = ppi_pkg::ST_MUL;
            end
            ppi_pkg::ST_MUL:  state_next = ppi_pkg::ST_SAT;
            ppi_pkg::ST_DIV:
                if (stat.div_done) state_next = ppi_pkg::ST_SAT;
            ppi_pkg::ST_SAT:  state_next = ppi_pkg::ST_GAIN;
            ppi_pkg::ST_GAIN: state_next = ppi_pkg::ST_ROT;
            ppi_pkg::ST_ROT:
                if (stat.rot_done) state_next = ppi_pkg::ST_SUM;
            ppi_pkg::ST_SUM:  state_next = ppi_pkg::ST_OUT;
            ppi_pkg::ST_OUT:
                if (!out_busy || out_fire) state_next = ppi_pkg::ST_IDLE;
            default: state_next = ppi_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd = '0;
        cmd.capture  = in_fire;
        cmd.body     = (state_reg == ppi_pkg::ST_BODY);
        cmd.mul      = (state_reg == ppi_pkg::ST_MUL);
        cmd.div_step = (state_reg == ppi_pkg::ST_DIV);
        cmd.sat      = (state_reg == ppi_pkg::ST_SAT);
        cmd.gain     = (state_reg == ppi_pkg::ST_GAIN);
        cmd.rot_step = (state_reg == ppi_pkg::ST_ROT);
        cmd.commit   = (state_reg == ppi_pkg::ST_SUM);
        ready        = (state_reg == ppi_pkg::ST_IDLE);
        load_out     = (state_reg == ppi_pkg::ST_OUT) && (!out_busy || out_fire);
    end

    `PPI_ASSERT_IMPL(a_accept_idle, clk, rst_n, in_fire, state_reg == ppi_pkg::ST_IDLE, "item accepted while busy")
    `PPI_ASSERT_NEXT(a_commit_out, clk, rst_n, cmd.commit, state_reg == ppi_pkg::ST_OUT, "commit not followed by output")
    `PPI_ASSERT_IMPL(a_load_free, clk, rst_n, load_out, !out_busy || out_fire, "output overwritten")
endmodule
`default_nettype wire

[hdl/ppi_datapath.sv]
// Pose datapath: body step, divider, CORDIC rotation and pose registers.
// Depends on ppi_pkg.
`default_nettype none
module ppi_datapath #(
    parameter int POS_WIDTH     = ppi_pkg::POS_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = ppi_pkg::ANGLE_WIDTH_DEF,
    parameter int COUNT_WIDTH   = ppi_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ppi_pkg::dp_cmd_t   cmd,
    output ppi_pkg::dp_stat_t       stat,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_idx,
    input  wire logic [31:0]        cfg_data,
    input  wire logic [1:0]         in_op,
    input  wire logic [2:0]         in_mode,
    input  wire logic signed [31:0] in_x,
    input  wire logic signed [31:0] in_y,
    input  wire logic [15:0]        in_hdg,
    output logic signed [31:0]      res_x,
    output logic signed [31:0]      res_y,
    output logic [15:0]             res_hdg,
    output logic [2:0]              res_mode,
    output logic [2:0]              res_prev,
    output logic [15:0]             res_count,
    output logic                    res_paused
);
    localparam int PW = POS_WIDTH;
    localparam int W  = PW + 3;            // CORDIC working width
    localparam int PS = 29 + ANGLE_WIDTH;  // crawl product shift
    localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};

    // Configuration registers.
    logic signed [31:0] cx_reg, cy_reg, crx_reg, cry_reg, mdx_reg, mdy_reg;
    logic signed [15:0] ts_reg;
    logic [15:0]        lim_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0; cy_reg <= '0; ts_reg <= '0; crx_reg <= '0;
            cry_reg <= '0; mdx_reg <= '0; mdy_reg <= '0;
            lim_reg <= ppi_pkg::STEP_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                ppi_pkg::REG_CENTRE_X:   cx_reg  <= cfg_data;
                ppi_pkg::REG_CENTRE_Y:   cy_reg  <= cfg_data;
                ppi_pkg::REG_TURN_STEP:  ts_reg  <= cfg_data[15:0];
                ppi_pkg::REG_CREEP_X:    crx_reg <= cfg_data;
                ppi_pkg::REG_CREEP_Y:    cry_reg <= cfg_data;
                ppi_pkg::REG_MOVE_DX:    mdx_reg <= cfg_data;
                ppi_pkg::REG_MOVE_DY:    mdy_reg <= cfg_data;
                ppi_pkg::REG_STEP_LIMIT: lim_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [COUNT_WIDTH-1:0] limit;
    assign limit = COUNT_WIDTH >= 16 ? COUNT_WIDTH'(lim_reg)
                                     : lim_reg[COUNT_WIDTH-1:0];

    // Pose state.
    logic signed [PW-1:0]    px_reg, py_reg;
    logic [ANGLE_WIDTH-1:0]  hdg_reg;
    logic [2:0]              mode_reg, prev_reg;
    logic [COUNT_WIDTH:0]    cnt_reg;

    // Captured item.
    logic [1:0]         op_reg;
    logic [2:0]         nm_reg;
    logic signed [31:0] lx_reg, ly_reg;
    logic [15:0]        lh_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= in_op; nm_reg <= in_mode;
            lx_reg <= in_x; ly_reg <= in_y; lh_reg <= in_hdg;
        end
    end

    logic moving;
    assign moving = mode_reg == ppi_pkg::MODE_CRAWL || mode_reg == ppi_pkg::MODE_CREEP
                 || mode_reg == ppi_pkg::MODE_TARGET;
    assign stat.is_tick_moving = (op_reg == ppi_pkg::OP_TICK) && moving;
    assign stat.is_target      = mode_reg == ppi_pkg::MODE_TARGET;

    // Crawl products: centre times turn step, registered with their signs.
    logic signed [47:0] prx_reg, pry_reg;   // centre_y*ts, -centre_x*ts source
    logic               pneg_x, pneg_y;
    logic [47:0]        mag_x, mag_y;
    logic signed [47:0] prod_y, prod_x;
    assign prod_y = 48'(cy_reg) * 48'(ts_reg);
    assign prod_x = 48'(cx_reg) * 48'(ts_reg);

    // Divider: restoring, magnitude, one bit per cycle for both axes.
    logic [31:0]  dqx_reg, dqy_reg;
    logic [32:0]  drx_reg, dry_reg;
    logic [5:0]   dcnt_reg;
    logic         dnx_reg, dny_reg;
    logic [16:0]  divisor;
    assign divisor = (limit == '0) ? 17'd1 : 17'(limit);
    assign stat.div_done = (dcnt_reg == 6'd31);

    // Rounded magnitude times 2*pi: the upper 24 bits are multiplied and registered in
    // the multiply state, the lower 24 bits in the saturation cycle.
    logic [55:0] hix_reg, hiy_reg;
    logic [55:0] lox, loy;
    logic [56:0] tx, ty;
    logic [49:0] rsx, rsy;
    assign mag_x = pneg_x ? 48'(-prx_reg) : 48'(prx_reg);
    assign mag_y = pneg_y ? 48'(-pry_reg) : 48'(pry_reg);
    assign lox = 56'(mag_x[23:0]) * 56'(ppi_pkg::TWO_PI_Q29);
    assign loy = 56'(mag_y[23:0]) * 56'(ppi_pkg::TWO_PI_Q29);
    assign tx  = 57'(hix_reg) + 57'(lox >> 24);
    assign ty  = 57'(hiy_reg) + 57'(loy >> 24);
    assign rsx = 50'((tx + (57'd1 << (PS-25))) >> (PS-24));
    assign rsy = 50'((ty + (57'd1 << (PS-25))) >> (PS-24));

    function automatic logic signed [PW-1:0] sat_p(input logic signed [49:0] v);
        logic signed [PW-1:0] r;
        if (v > 50'(PMAX))      r = PMAX;
        else if (v < 50'(PMIN)) r = PMIN;
        else                    r = v[PW-1:0];
        return r;
    endfunction

    // Gain prescale: round(|v|*gain / 2^31) with sign.
    function automatic logic signed [W-1:0] gain_mul(input logic signed [PW-1:0] v);
        logic [PW-1:0]   m;
        logic [PW+31:0]  p;
        logic [PW:0]     q;
        m = v[PW-1] ? PW'(-v) : PW'(v);
        p = (PW+32)'(m) * (PW+32)'(ppi_pkg::GAIN_Q31);
        q = (PW+1)'((p + ((PW+32)'(1) << 30)) >> 31);
        return v[PW-1] ? -W'(q) : W'(q);
    endfunction

    logic signed [PW-1:0] sx_reg, sy_reg;
    logic signed [W-1:0]  rx_reg, ry_reg;
    logic signed [33:0]   z_reg;
    logic [4:0]           it_reg;
    logic [31:0]          ang32;
    logic signed [W-1:0]  gx, gy;
    assign ang32 = {hdg_reg, {(32-ANGLE_WIDTH){1'b0}}};
    assign gx = gain_mul(sx_reg);
    assign gy = gain_mul(sy_reg);
    assign stat.rot_done = (it_reg == 5'(ppi_pkg::ROT_STEPS - 1));

    logic signed [W-1:0] shx, shy;
    assign shx = ry_reg >>> it_reg;
    assign shy = rx_reg >>> it_reg;

    // Sequenced arithmetic.
    always_ff @(posedge clk)
    begin
        if (cmd.body)
        begin
            prx_reg <= prod_y; pry_reg <= prod_x;
            pneg_x <= prod_y < 0; pneg_y <= prod_x < 0;
            dqx_reg <= mdx_reg[31] ? 32'(-mdx_reg) : 32'(mdx_reg);
            dqy_reg <= mdy_reg[31] ? 32'(-mdy_reg) : 32'(mdy_reg);
            dnx_reg <= mdx_reg[31]; dny_reg <= mdy_reg[31];
            drx_reg <= '0; dry_reg <= '0; dcnt_reg <= '0;
        end
        if (cmd.mul)
        begin
            hix_reg <= 56'(mag_x[47:24]) * 56'(ppi_pkg::TWO_PI_Q29);
            hiy_reg <= 56'(mag_y[47:24]) * 56'(ppi_pkg::TWO_PI_Q29);
        end
        if (cmd.div_step)
        begin
            if ({drx_reg[31:0], dqx_reg[31]} >= 33'(divisor))
            begin
                drx_reg <= {drx_reg[31:0], dqx_reg[31]} - 33'(divisor);
                dqx_reg <= {dqx_reg[30:0], 1'b1};
            end
            else
            begin
                drx_reg <= {drx_reg[31:0], dqx_reg[31]};
                dqx_reg <= {dqx_reg[30:0], 1'b0};
            end
            if ({dry_reg[31:0], dqy_reg[31]} >= 33'(divisor))
            begin
                dry_reg <= {dry_reg[31:0], dqy_reg[31]} - 33'(divisor);
                dqy_reg <= {dqy_reg[30:0], 1'b1};
            end
            else
            begin
                dry_reg <= {dry_reg[31:0], dqy_reg[31]};
                dqy_reg <= {dqy_reg[30:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 6'd1;
        end
        if (cmd.sat)
        begin
            if (stat.is_target)
            begin
                sx_reg <= sat_p(dnx_reg ? -50'(dqx_reg) : 50'(dqx_reg));
                sy_reg <= sat_p(dny_reg ? -50'(dqy_reg) : 50'(dqy_reg));
            end
            else if (mode_reg == ppi_pkg::MODE_CREEP)
            begin
                sx_reg <= sat_p((pneg_x ? -rsx : rsx) + 50'(crx_reg));
                sy_reg <= sat_p(-(pneg_y ? -rsy : rsy) + 50'(cry_reg));
            end
            else
            begin
                sx_reg <= sat_p(pneg_x ? -rsx : rsx);
                sy_reg <= sat_p(-(pneg_y ? -rsy : rsy));
            end
        end
        if (cmd.gain)
        begin
            unique case (ang32[31:30])
                2'd0: begin rx_reg <= gx;  ry_reg <= gy;  end
                2'd1: begin rx_reg <= -gy; ry_reg <= gx;  end
                2'd2: begin rx_reg <= -gx; ry_reg <= -gy; end
                default: begin rx_reg <= gy; ry_reg <= -gx; end
            endcase
            z_reg <= 34'(ang32[29:0]);
            it_reg <= '0;
        end
        if (cmd.rot_step)
        begin
            if (z_reg >= 0)
            begin
                rx_reg <= rx_reg - shx; ry_reg <= ry_reg + shy;
                z_reg <= z_reg - 34'(ppi_pkg::atan_entry(it_reg));
            end
            else
            begin
                rx_reg <= rx_reg + shx; ry_reg <= ry_reg - shy;
                z_reg <= z_reg + 34'(ppi_pkg::atan_entry(it_reg));
            end
            it_reg <= it_reg + 5'd1;
        end
    end

    // Write back on commit.
    logic signed [W:0]      sumx, sumy;
    logic [COUNT_WIDTH:0]   cnt_new;
    logic                   over;
    logic [ANGLE_WIDTH-1:0] ts_a;
    assign sumx = (W+1)'(px_reg) + (W+1)'(rx_reg);
    assign sumy = (W+1)'(py_reg) + (W+1)'(ry_reg);
    assign ts_a = ANGLE_WIDTH'(ts_reg);
    assign cnt_new = stat.is_tick_moving ? cnt_reg + 1'b1 : cnt_reg;
    assign over = cnt_new > (COUNT_WIDTH+1)'(limit);

    function automatic logic signed [PW-1:0] sat_s(input logic signed [W:0] v);
        logic signed [PW-1:0] r;
        if (v > (W+1)'(PMAX))      r = PMAX;
        else if (v < (W+1)'(PMIN)) r = PMIN;
        else                       r = v[PW-1:0];
        return r;
    endfunction

    function automatic logic signed [PW-1:0] sat32(input logic signed [31:0] v);
        logic signed [PW-1:0] r;
        if (PW >= 32)                        r = PW'(v);
        else if (v > 32'(PMAX))              r = PMAX;
        else if (v < 32'(PMIN))              r = PMIN;
        else                                 r = v[PW-1:0];
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg <= '0; py_reg <= '0; hdg_reg <= '0;
            mode_reg <= ppi_pkg::MODE_STOP; prev_reg <= ppi_pkg::MODE_STOP;
            cnt_reg <= '0; res_paused <= 1'b0;
        end
        else if (cmd.commit)
        begin
            res_paused <= 1'b0;
            priority case (op_reg)
                ppi_pkg::OP_TICK:
                begin
                    if (stat.is_tick_moving)
                    begin
                        px_reg <= sat_s(sumx); py_reg <= sat_s(sumy);
                        if (!stat.is_target) hdg_reg <= hdg_reg + ts_a;
                    end
                    if (over)
                    begin
                        cnt_reg <= '0; prev_reg <= mode_reg;
                        mode_reg <= ppi_pkg::MODE_PAUSE; res_paused <= 1'b1;
                    end
                    else
                        cnt_reg <= cnt_new;
                end
                ppi_pkg::OP_SET:
                    if (nm_reg <= ppi_pkg::MODE_TARGET)
                    begin
                        prev_reg <= mode_reg; mode_reg <= nm_reg;
                    end
                ppi_pkg::OP_LOAD:
                begin
                    px_reg <= sat32(lx_reg); py_reg <= sat32(ly_reg);
                    hdg_reg <= ANGLE_WIDTH'(lh_reg);
                end
                default: ;
            endcase
        end
    end

    // Result fields, clamped to 32 bits.
    function automatic logic signed [31:0] out32(input logic signed [PW-1:0] v);
        logic signed [31:0] r;
        if (PW <= 32)                  r = 32'(v);
        else if (v > PW'(32'sh7FFFFFFF)) r = 32'sh7FFFFFFF;
        else if (v < PW'(-33'sh80000000)) r = 32'sh80000000;
        else                           r = 32'(v);
        return r;
    endfunction
    assign res_x     = out32(px_reg);
    assign res_y     = out32(py_reg);
    assign res_hdg   = 16'(hdg_reg);
    assign res_mode  = mode_reg;
    assign res_prev  = prev_reg;
    assign res_count = 16'(cnt_reg);
endmodule
`default_nettype wire

[hdl/planar_pose_integrator_core.sv]
// Top level of the planar pose integrator: stream ports, controller, datapath.
// Depends on ppi_pkg, ppi_ctrl and ppi_datapath.
//
// Usage: items arrive on the s_axis channel; each gives exactly one result item
// on m_axis carrying the pose, mode, previous mode, count and a pause flag.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata; the user
// must write them only while idle, which the block itself does not enforce.
// A set, load, no-op or stationary tick goes straight to write-back and output; a
// crawl tick first forms the crawl product and the two-part scale, then runs the 28
// CORDIC micro-rotations; a target tick runs the 32-step divider before the rotation.
// One item is worked on at a time; s_axis_tready is high only when idle, so a new
// item is taken only once the last result has been loaded into the output register.
// The result waits in an output register; while the receiver stalls, the next item
// may be taken and computed, and it waits until the held result is taken.
// Reset clears pose, modes, count and the output valid; step_limit resets to 10000.
`default_nettype none
module planar_pose_integrator_core #(
    parameter int POS_WIDTH     = ppi_pkg::POS_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = ppi_pkg::ANGLE_WIDTH_DEF,
    parameter int COUNT_WIDTH   = ppi_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // operation[1:0], new_mode[4:2], load_x[36:5], load_y[68:37], load_heading[84:69]
    input  wire logic [87:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pos_x[31:0], pos_y[63:32], heading[79:64], mode[82:80], prev_mode[85:83],
    // step_count[101:86], paused_now[102]
    output logic [103:0]      m_axis_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata
);
    ppi_pkg::dp_cmd_t  cmd;
    ppi_pkg::dp_stat_t stat;
    logic in_fire, out_fire, load_out;
    logic signed [31:0] rx, ry;
    logic [15:0] rh, rc;
    logic [2:0]  rm, rp;
    logic        rpz;
    logic        ovalid_reg;
    logic [103:0] odata_reg;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = ovalid_reg && m_axis_tready;

    ppi_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_busy(ovalid_reg),
        .out_fire(out_fire), .stat(stat), .cmd(cmd), .ready(s_axis_tready),
        .load_out(load_out)
    );

    ppi_datapath #(
        .POS_WIDTH(POS_WIDTH), .ANGLE_WIDTH(ANGLE_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_idx(cfg_addr), .cfg_data(cfg_wdata),
        .in_op(s_axis_tdata[1:0]), .in_mode(s_axis_tdata[4:2]),
        .in_x(s_axis_tdata[36:5]), .in_y(s_axis_tdata[68:37]),
        .in_hdg(s_axis_tdata[84:69]),
        .res_x(rx), .res_y(ry), .res_hdg(rh), .res_mode(rm), .res_prev(rp),
        .res_count(rc), .res_paused(rpz)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (load_out)
            ovalid_reg <= 1'b1;
        else if (out_fire)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            odata_reg <= {1'b0, rpz, rc, rp, rm, rh, ry, rx};
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
endmodule
`default_nettype wire

[test/pose_checker.sv]
// Checker for the planar pose integrator: watches the input, result and
// register-write channels, predicts each result and compares it field by field.
// Depends on ppi_pkg for the mode and register codes.
module pose_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [87:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    output int           fail_count,
    output int           pending
);
    localparam logic [63:0] TWO_PI = 64'd3373259426;
    localparam logic [63:0] GAIN   = 64'd1304065748;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] heading;
        logic [2:0]  mode;
        logic [2:0]  prev_mode;
        logic [15:0] step_count;
        logic        paused_now;
    } pose_result_t;

    // Arctangent of 2^-i as a 32-bit binary angle.
    logic [31:0] arc_steps [28] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    // Register copies.
    longint      centre_x, centre_y, turn_step, creep_x, creep_y, move_dx, move_dy;
    logic [15:0] step_limit;

    // Pose state.
    longint      pose_x, pose_y;
    logic [15:0] pose_heading;
    logic [2:0]  cur_mode, old_mode;
    int          ticks;

    pose_result_t results_due[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Rounded |a| * k / 2^s with the sign of a, half away from zero.
    function automatic longint scaled(input longint a, input logic [63:0] k, input int s);
        logic        neg;
        logic [63:0] m, hi, lo, t;
        neg = a < 0;
        m   = neg ? -a : a;
        hi  = (m >> 24) * k;
        lo  = ((m & 64'hFFFFFF) * k) >> 24;
        t   = hi + lo;
        t   = (t + (64'd1 << (s - 25))) >> (s - 24);
        return neg ? -longint'(t) : longint'(t);
    endfunction

    // Gain prescale, exact quadrant turn, then CORDIC micro-rotations.
    function automatic void rotate_by_heading(input longint bx, input longint by,
                                              input logic [31:0] ang,
                                              output longint rx, output longint ry);
        longint x, y, t, z, dx, dy;
        x = scaled(bx, GAIN, 31);
        y = scaled(by, GAIN, 31);
        case (ang[31:30])
            2'd1:    begin t = x; x = -y; y = t; end
            2'd2:    begin x = -x; y = -y; end
            2'd3:    begin t = x; x = y; y = -t; end
            default: ;
        endcase
        z = longint'({34'd0, ang[29:0]});
        for (int i = 0; i < 28; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - longint'(arc_steps[i]);
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + longint'(arc_steps[i]);
            end
        end
        rx = x;
        ry = y;
    endfunction

    function automatic void switch_mode(input logic [2:0] m);
        old_mode = cur_mode;
        cur_mode = m;
    endfunction

    // Advances the pose state by one input item and returns the result.
    function automatic pose_result_t advance_pose(input logic [87:0] d);
        logic [1:0]   op;
        logic [2:0]   nm;
        logic         paused;
        longint       bx, by, rx, ry, div;
        pose_result_t r;
        op     = d[1:0];
        nm     = d[4:2];
        paused = 1'b0;
        if (op == ppi_pkg::OP_TICK)
        begin
            if (cur_mode == ppi_pkg::MODE_CRAWL || cur_mode == ppi_pkg::MODE_CREEP ||
                cur_mode == ppi_pkg::MODE_TARGET)
            begin
                if (cur_mode == ppi_pkg::MODE_TARGET)
                begin
                    div = (step_limit != 0) ? longint'(step_limit) : 1;
                    bx  = move_dx / div;
                    by  = move_dy / div;
                end
                else
                begin
                    bx = scaled(centre_y * turn_step, TWO_PI, 45);
                    by = -scaled(centre_x * turn_step, TWO_PI, 45);
                    if (cur_mode == ppi_pkg::MODE_CREEP)
                    begin
                        bx = bx + creep_x;
                        by = by + creep_y;
                    end
                end
                rotate_by_heading(clamp32(bx), clamp32(by), {pose_heading, 16'd0}, rx, ry);
                pose_x = clamp32(pose_x + rx);
                pose_y = clamp32(pose_y + ry);
                if (cur_mode != ppi_pkg::MODE_TARGET)
                    pose_heading = pose_heading + turn_step[15:0];
                ticks++;
            end
            if (ticks > int'(step_limit))
            begin
                ticks = 0;
                switch_mode(ppi_pkg::MODE_PAUSE);
                paused = 1'b1;
            end
        end
        else if (op == ppi_pkg::OP_SET)
        begin
            if (nm <= ppi_pkg::MODE_TARGET)
                switch_mode(nm);
        end
        else if (op == ppi_pkg::OP_LOAD)
        begin
            pose_x       = longint'($signed(d[36:5]));
            pose_y       = longint'($signed(d[68:37]));
            pose_heading = d[84:69];
        end
        r.pos_x      = pose_x[31:0];
        r.pos_y      = pose_y[31:0];
        r.heading    = pose_heading;
        r.mode       = cur_mode;
        r.prev_mode  = old_mode;
        r.step_count = ticks[15:0];
        r.paused_now = paused;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pose_result_t want;
        if (!rst_n)
        begin
            centre_x = 0; centre_y = 0; turn_step = 0; creep_x = 0; creep_y = 0;
            move_dx = 0; move_dy = 0; step_limit = ppi_pkg::STEP_LIMIT_RESET;
            pose_x = 0; pose_y = 0; pose_heading = '0;
            cur_mode = ppi_pkg::MODE_STOP; old_mode = ppi_pkg::MODE_STOP; ticks = 0;
            results_due.delete();
            fail_count = 0;
        end
        else
        begin
            // Register writes.
            if (cfg_we)
            begin
                case (cfg_addr)
                    ppi_pkg::REG_CENTRE_X:   centre_x   = longint'($signed(cfg_wdata));
                    ppi_pkg::REG_CENTRE_Y:   centre_y   = longint'($signed(cfg_wdata));
                    ppi_pkg::REG_TURN_STEP:  turn_step  = longint'($signed(cfg_wdata[15:0]));
                    ppi_pkg::REG_CREEP_X:    creep_x    = longint'($signed(cfg_wdata));
                    ppi_pkg::REG_CREEP_Y:    creep_y    = longint'($signed(cfg_wdata));
                    ppi_pkg::REG_MOVE_DX:    move_dx    = longint'($signed(cfg_wdata));
                    ppi_pkg::REG_MOVE_DY:    move_dy    = longint'($signed(cfg_wdata));
                    ppi_pkg::REG_STEP_LIMIT: step_limit = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            // Accepted input item.
            if (s_axis_tvalid && s_axis_tready)
                results_due.push_back(advance_pose(s_axis_tdata));
            // Accepted result item.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result item with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("pos_x", want.pos_x, m_axis_tdata[31:0]);
                    check_field("pos_y", want.pos_y, m_axis_tdata[63:32]);
                    check_field("heading", 32'(want.heading), 32'(m_axis_tdata[79:64]));
                    check_field("mode", 32'(want.mode), 32'(m_axis_tdata[82:80]));
                    check_field("prev_mode", 32'(want.prev_mode), 32'(m_axis_tdata[85:83]));
                    check_field("step_count", 32'(want.step_count),
                                32'(m_axis_tdata[101:86]));
                    check_field("paused_now", 32'(want.paused_now), 32'(m_axis_tdata[102]));
                end
            end
        end
        pending = results_due.size();
    end
endmodule

[test/testbench.sv]
// Top of the pose integrator testbench: clock, reset, stimulus and verdict.
// Depends on ppi_pkg, planar_pose_integrator_core and pose_checker.
module testbench;
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int QUIET_LIMIT = 5000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [31:0]  cfg_wdata;
    int           fail_count;
    int           pending;
    int           quiet_cycles;
    logic         calm;
    int           stall_left;

    planar_pose_integrator_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    pose_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        calm = 1'b0;
        stall_left = 0;
        quiet_cycles = 0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Random idle length: mostly none or short, a few long.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            stall_left <= idle_length();
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog over cycles in which nothing is accepted.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [87:0] pack_item(input logic [1:0] op, input logic [2:0] nm,
                                              input logic [31:0] lx, input logic [31:0] ly,
                                              input logic [15:0] lh);
        return {3'd0, lh, ly, lx, nm, op};
    endfunction

    task automatic send_item(input logic [87:0] d);
        int gap;
        gap = idle_length();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge clk iff s_axis_tready);
    endtask

    task automatic tick_item();
        send_item(pack_item(ppi_pkg::OP_TICK, 3'($urandom), $urandom, $urandom,
                            16'($urandom)));
    endtask

    task automatic set_mode(input logic [2:0] m);
        send_item(pack_item(ppi_pkg::OP_SET, m, $urandom, $urandom, 16'($urandom)));
    endtask

    // Waits until every result has come and the block has settled.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] cx, input logic [31:0] cy,
                             input logic [15:0] ts, input logic [31:0] kx,
                             input logic [31:0] ky, input logic [31:0] mx,
                             input logic [31:0] my, input logic [15:0] lim);
        drain();
        write_reg(ppi_pkg::REG_CENTRE_X, cx);
        write_reg(ppi_pkg::REG_CENTRE_Y, cy);
        write_reg(ppi_pkg::REG_TURN_STEP, {16'd0, ts});
        write_reg(ppi_pkg::REG_CREEP_X, kx);
        write_reg(ppi_pkg::REG_CREEP_Y, ky);
        write_reg(ppi_pkg::REG_MOVE_DX, mx);
        write_reg(ppi_pkg::REG_MOVE_DY, my);
        write_reg(ppi_pkg::REG_STEP_LIMIT, {16'd0, lim});
    endtask

    // A random value spread over all magnitudes.
    function automatic logic [31:0] spread();
        return $signed($urandom) >>> $urandom_range(0, 31);
    endfunction

    initial
    begin
        int r;
        logic [2:0] nm;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every operation and mode, bad modes, no-op.
        write_all(32'h0001_0000, 32'hFFFE_0000, 16'd1000, 32'h0000_8000, 32'hFFFF_C000,
                  32'h7FFF_FFFF, 32'h8000_0000, 16'd3);
        send_item(pack_item(ppi_pkg::OP_LOAD, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF));
        tick_item();
        set_mode(ppi_pkg::MODE_CRAWL);
        tick_item();
        tick_item();
        set_mode(ppi_pkg::MODE_CREEP);
        tick_item();
        set_mode(ppi_pkg::MODE_TARGET);
        tick_item();
        tick_item();
        set_mode(3'd5);
        set_mode(3'd7);
        send_item(pack_item(OP_NOP, 3'd2, 32'hFFFF_FFFF, 32'h0, 16'h0));
        set_mode(ppi_pkg::MODE_STOP);
        send_item(pack_item(ppi_pkg::OP_LOAD, 3'd0, 32'h0, 32'h0, 16'h0));
        tick_item();
        set_mode(ppi_pkg::MODE_PAUSE);
        tick_item();
        // Zero limit: the target step divides by one and every moving tick pauses.
        write_all(32'h0001_0000, 32'hFFFE_0000, 16'd1000, 32'h0000_8000, 32'hFFFF_C000,
                  32'h0123_4567, 32'hFEDC_BA98, 16'd0);
        set_mode(ppi_pkg::MODE_TARGET);
        tick_item();
        // Lowering the limit below the count pauses a stopped block.
        write_all(32'h0001_0000, 32'hFFFE_0000, 16'd1000, 32'h0000_8000, 32'hFFFF_C000,
                  32'h0123_4567, 32'hFEDC_BA98, 16'd10);
        set_mode(ppi_pkg::MODE_CRAWL);
        tick_item();
        tick_item();
        tick_item();
        set_mode(ppi_pkg::MODE_STOP);
        write_all(32'h0001_0000, 32'hFFFE_0000, 16'd1000, 32'h0000_8000, 32'hFFFF_C000,
                  32'h0123_4567, 32'hFEDC_BA98, 16'd1);
        tick_item();

        // Random phases under several register settings, extremes first.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
                1: write_all(32'h8000_0000, 32'h8000_0000, 16'h8000, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd1);
                default: write_all(spread(), spread(), 16'($urandom), spread(), spread(),
                                   spread(), spread(), 16'($urandom_range(0, 40)));
            endcase
            calm = (phase == 3);
            for (int n = 0; n < 105; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 68)
                    tick_item();
                else if (r < 82)
                begin
                    nm = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(2, 4)) : 3'($urandom);
                    set_mode(nm);
                end
                else if (r < 95)
                    send_item(pack_item(ppi_pkg::OP_LOAD, 3'($urandom), $urandom, $urandom,
                                        16'($urandom)));
                else
                    send_item(pack_item(OP_NOP, 3'($urandom), $urandom, $urandom,
                                        16'($urandom)));
            end
        end
        calm = 1'b0;

        // Let every result come, then give the verdict.
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[filelist.f]
+incdir+hdl
hdl/ppi_pkg.sv
hdl/ppi_ctrl.sv
hdl/ppi_datapath.sv
hdl/planar_pose_integrator_core.sv
test/pose_checker.sv
test/testbench.sv
